### rtl/core/bpf_pkg.sv
// Shared constants and types for the blended pixel framebuffer.
`default_nettype none

package bpf_pkg;

  localparam int CFG_DW = 9;
  localparam int CFG_IW = 2;
  localparam int IDX_W  = 18;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_PAINT = 2'd1;
  localparam logic [1:0] REQ_GET   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TRANSP = 2'd2;

  localparam logic [31:0] FILL_WHITE = 32'hFFFF_FFFF;
  localparam logic [31:0] FILL_CLEAR = 32'h0000_0000;

  // idx carries the pixel index, or the pixel count for a clear
  typedef struct packed {
    logic [1:0]       op;
    logic             inb;
    logic             fits;
    logic [IDX_W-1:0] idx;
    logic [31:0]      colour;
  } bpf_job_t;

endpackage

`default_nettype wire

### rtl/core/bpf_channels.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface bpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        colour;

  modport source (output valid, output req_type, output pos_x, output pos_y,
                  output colour, input ready);
  modport sink   (input valid, input req_type, input pos_x, input pos_y,
                  input colour, output ready);
endinterface

interface bpf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_pixel;
  logic        in_bounds;

  modport source (output valid, output read_pixel, output in_bounds, input ready);
  modport sink   (input valid, input read_pixel, input in_bounds, output ready);
endinterface

interface bpf_cfg_if;
  import bpf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bpf_front.sv
// Front end: config registers, bounds test and pixel index per request.
`default_nettype none

module bpf_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [1:0]                  in_req,
  input  logic [15:0]                 in_x,
  input  logic [15:0]                 in_y,
  input  logic [31:0]                 in_colour,
  output logic                        in_ready,
  input  logic                        cfg_valid,
  input  logic [bpf_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bpf_pkg::CFG_DW-1:0]  cfg_data,
  output logic                        cfg_ready,
  input  logic                        q_full,
  output logic                        q_push,
  output bpf_pkg::bpf_job_t           q_job
);
  import bpf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [CFG_DW-1:0] frame_width_r;
  logic [CFG_DW-1:0] frame_height_r;
  logic              transp_r;

  logic [CFG_DW-1:0] eff_w;
  logic [CFG_DW-1:0] eff_h;
  logic              inb;
  logic [IDX_W-1:0]  row_base;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  span;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= '0;
      frame_height_r <= '0;
      transp_r       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  frame_width_r  <= cfg_data;
        CFG_HEIGHT: frame_height_r <= cfg_data;
        CFG_TRANSP: transp_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign eff_w = (32'(frame_width_r) > MAX_WIDTH) ? CFG_DW'(MAX_WIDTH) : frame_width_r;
  assign eff_h = (32'(frame_height_r) > MAX_HEIGHT) ? CFG_DW'(MAX_HEIGHT) : frame_height_r;

  assign inb = !in_x[15] && !in_y[15] && (in_x < 16'(eff_w)) && (in_y < 16'(eff_h));

  assign row_base = IDX_W'(in_y[CFG_DW-1:0]) * IDX_W'(eff_w);
  assign idx      = row_base + IDX_W'(in_x[CFG_DW-1:0]);
  assign span     = IDX_W'(eff_w) * IDX_W'(eff_h);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_job.op     = in_req;
    q_job.inb    = inb && (in_req != REQ_CLEAR);
    q_job.fits   = 32'(idx) < DEPTH;
    q_job.idx    = (in_req == REQ_CLEAR) ? span : idx;
    q_job.colour = in_colour;
    if (in_req == REQ_CLEAR) begin
      q_job.colour = transp_r ? FILL_CLEAR : FILL_WHITE;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bpf_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none

module bpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bpf_pkg::bpf_job_t push_job,
  output logic              full,
  input  logic              pop,
  output bpf_pkg::bpf_job_t head,
  output logic              empty
);
  import bpf_pkg::*;

  localparam int Q_DEPTH = 2;

  bpf_job_t   slot_r [Q_DEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full  = cnt_r == 2'(Q_DEPTH);
  assign empty = cnt_r == 2'd0;
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/bpf_back.sv
// Back end: pixel memory, read-modify-write blend, clear sweep, result register.
`default_nettype none

module bpf_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bpf_pkg::bpf_job_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_pixel,
  output logic              out_inb
);
  import bpf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  // exact floor(v / 255) for v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] sa, input logic [7:0] s,
                                     input logic [7:0] d);
    logic [15:0] ps;
    logic [15:0] pd;
    ps = 16'(sa) * 16'(s);
    pd = 16'(8'd255 - sa) * 16'(d);
    return div255(16'(ps + pd));
  endfunction

  function automatic logic [31:0] blend_over(input logic [31:0] dst, input logic [31:0] src);
    logic [7:0]  da;
    logic [7:0]  sa;
    logic [15:0] pa;
    logic [7:0]  a;
    da = dst[31:24];
    sa = src[31:24];
    pa = 16'(sa) * 16'(8'd255 - da);
    a  = 8'(da + div255(pa));
    return {a, mix(sa, src[23:16], dst[23:16]), mix(sa, src[15:8], dst[15:8]),
            mix(sa, src[7:0], dst[7:0])};
  endfunction

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] cnt_nxt;
  bpf_job_t         job_r;
  logic [31:0]      hold_pix_r;
  logic             hold_inb_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [31:0]      out_pix_r;
  logic             out_inb_r;

  logic             out_free;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic             mem_re;
  logic             res_fire;
  logic [31:0]      res_pix;
  logic             res_inb;
  logic             out_load;
  logic [31:0]      load_pix;
  logic             load_inb;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(q_head.idx);
    mem_wdata = q_head.colour;
    mem_re    = 1'b0;
    res_fire  = 1'b0;
    res_pix   = '0;
    res_inb   = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            REQ_CLEAR: begin
              if (q_head.idx == '0) begin
                res_fire = 1'b1;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_CLEAR;
              end
            end
            REQ_PUT: begin
              res_fire = 1'b1;
              res_inb  = q_head.inb;
              mem_we   = q_head.inb && q_head.fits;
            end
            default: begin
              if (q_head.inb && q_head.fits) begin
                mem_re    = 1'b1;
                state_nxt = S_READ;
              end else begin
                res_fire = 1'b1;
                res_inb  = q_head.inb;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_fire  = 1'b1;
        res_inb   = 1'b1;
        mem_waddr = AW'(job_r.idx);
        mem_wdata = blend_over(rd_data_r, job_r.colour);
        if (job_r.op == REQ_PAINT) begin
          mem_we = 1'b1;
        end else begin
          res_pix = rd_data_r;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = job_r.colour;
        if (cnt_r + IDX_W'(1) == job_r.idx) begin
          res_fire = 1'b1;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (res_fire) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign out_load = out_free && (res_fire || state_r == S_HOLD);
  assign load_pix = (state_r == S_HOLD) ? hold_pix_r : res_pix;
  assign load_inb = (state_r == S_HOLD) ? hold_inb_r : res_inb;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[AW'(q_head.idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (res_fire && !out_free) begin
      hold_pix_r <= res_pix;
      hold_inb_r <= res_inb;
    end
    if (out_load) begin
      out_pix_r <= load_pix;
      out_inb_r <= load_inb;
    end
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pix_r;
  assign out_inb   = out_inb_r;

endmodule

`default_nettype wire

### rtl/core/blended_pixel_framebuffer.sv
// Top level of the blended pixel framebuffer.
//
//   channel   | dir | transfer when        | payload
//   in_chan   | in  | valid && ready       | req_type, pos_x, pos_y, colour
//   out_chan  | out | valid && ready       | read_pixel, in_bounds
//   cfg_chan  | in  | valid (ready tied 1) | index, data
//
// Put and out-of-bounds requests finish in the back end's idle state; in-bounds
// get and paint first read memory, then give the result and the blend write-back;
// clear writes width*height pixels, one pixel per cycle after dispatch.
// A request is registered in the two-entry queue before the back end takes it.
// Reset clears control state only; pixel RAM holds garbage until written.
// The queue keeps taking requests while a result waits on out_chan, until it is full.
`default_nettype none

module blended_pixel_framebuffer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  bpf_in_if.sink    in_chan,
  bpf_out_if.source out_chan,
  bpf_cfg_if.sink   cfg_chan
);
  import bpf_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  bpf_job_t push_job;
  bpf_job_t head_job;

  bpf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_req    (in_chan.req_type),
    .in_x      (in_chan.pos_x),
    .in_y      (in_chan.pos_y),
    .in_colour (in_chan.colour),
    .in_ready  (in_chan.ready),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .cfg_ready (cfg_chan.ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  bpf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pixel (out_chan.read_pixel),
    .out_inb   (out_chan.in_bounds)
  );

endmodule

`default_nettype wire

### rtl/core/bpf_checker.sv
// Port-level checker for the framebuffer, with its bind statement.
`default_nettype none

module bpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        out_inb
);

  logic [2:0] pending_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inb |-> out_pixel == 32'd0)
    else $error("out-of-bounds result carries a pixel");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without an outstanding request");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind blended_pixel_framebuffer bpf_checker u_bpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pixel (out_chan.read_pixel),
  .out_inb   (out_chan.in_bounds)
);

`default_nettype wire

### sim/blended_pixel_framebuffer_checker.sv
// Checker for the blended pixel framebuffer: predicts each reply and compares it.
module blended_pixel_framebuffer_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst_n,
  bpf_in_if    in_mon,
  bpf_out_if   out_mon,
  bpf_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpf_pkg::*;

  typedef struct packed {
    logic [31:0] pixel;
    logic        inb;
  } fb_reply_t;

  logic [31:0]       frame_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [CFG_DW-1:0] width_reg;
  logic [CFG_DW-1:0] height_reg;
  logic              transp_reg;
  fb_reply_t         expected_replies [$];
  int                errors = 0;

  function automatic logic [7:0] mix_chan(logic [7:0] sa, logic [7:0] s, logic [7:0] d);
    int unsigned a_s;
    int unsigned v_s;
    int unsigned v_d;
    a_s = sa;
    v_s = s;
    v_d = d;
    return 8'((a_s * v_s + (255 - a_s) * v_d) / 255);
  endfunction

  function automatic logic [31:0] over_blend(logic [31:0] dst, logic [31:0] src);
    int unsigned da;
    int unsigned sa;
    int unsigned alpha;
    da = dst[31:24];
    sa = src[31:24];
    alpha = da + (sa * (255 - da)) / 255;
    return {8'(alpha),
            mix_chan(src[31:24], src[23:16], dst[23:16]),
            mix_chan(src[31:24], src[15:8], dst[15:8]),
            mix_chan(src[31:24], src[7:0], dst[7:0])};
  endfunction

  function automatic fb_reply_t frame_request(logic [1:0] op, logic signed [15:0] x,
                                              logic signed [15:0] y, logic [31:0] colour);
    int        w;
    int        h;
    int        idx;
    fb_reply_t r;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    r = '0;
    if (op == REQ_CLEAR) begin
      for (int p = 0; p < w * h; p++) frame_mem[p] = transp_reg ? FILL_CLEAR : FILL_WHITE;
    end else if (x >= 0 && y >= 0 && int'(x) < w && int'(y) < h) begin
      idx = int'(y) * w + int'(x);
      r.inb = 1'b1;
      case (op)
        REQ_PUT: begin
          frame_mem[idx] = colour;
        end
        REQ_PAINT: begin
          frame_mem[idx] = over_blend(frame_mem[idx], colour);
        end
        default: begin
          r.pixel = frame_mem[idx];
        end
      endcase
    end
    return r;
  endfunction

  function automatic void check_reply(logic [31:0] pixel, logic inb);
    fb_reply_t e;
    if (expected_replies.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected reply pixel %08h in_bounds %0b", $time, pixel, inb);
    end else begin
      e = expected_replies.pop_front();
      if (e.pixel !== pixel || e.inb !== inb) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply mismatch: pixel exp %08h got %08h, in_bounds exp %0b got %0b",
                   $time, e.pixel, pixel, e.inb, inb);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = '0;
      height_reg = '0;
      transp_reg = 1'b0;
      expected_replies.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_reply(out_mon.read_pixel, out_mon.in_bounds);
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_WIDTH: begin
            width_reg = cfg_mon.data;
          end
          CFG_HEIGHT: begin
            height_reg = cfg_mon.data;
          end
          CFG_TRANSP: begin
            transp_reg = cfg_mon.data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_replies.push_back(frame_request(in_mon.req_type, in_mon.pos_x,
                                                 in_mon.pos_y, in_mon.colour));
    end
    fail_count <= errors;
    pending <= expected_replies.size();
  end

endmodule

### sim/blended_pixel_framebuffer_tb.sv
// Testbench top for the blended pixel framebuffer: stimulus, idling and verdict.
module blended_pixel_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpf_pkg::*;

  localparam int FRAME_MAX   = 256;
  localparam int STALL_LIMIT = 300000;
  localparam int NUM_PHASES  = 11;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   frame_w;
  int   frame_h;
  int   clear_tail;
  int   stall_cycles;
  bit   pixel_valid [0:FRAME_MAX*FRAME_MAX-1];

  int phase_w [NUM_PHASES] = '{5, 1, 16, 256, 3, 511, 257, 0, 12, 8, 256};
  int phase_h [NUM_PHASES] = '{7, 1, 9, 2, 256, 300, 1, 5, 0, 8, 256};
  int phase_t [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 1, 0, 0, 1};

  bpf_in_if  in_chan ();
  bpf_out_if out_chan ();
  bpf_cfg_if cfg_chan ();

  blended_pixel_framebuffer #(
    .MAX_WIDTH (FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  blended_pixel_framebuffer_checker #(
    .MAX_WIDTH (FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_mon   (cfg_chan),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("blended_pixel_framebuffer test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IW-1:0] index, input int value);
    if (index == CFG_WIDTH) frame_w = (value > FRAME_MAX) ? FRAME_MAX : value;
    if (index == CFG_HEIGHT) frame_h = (value > FRAME_MAX) ? FRAME_MAX : value;
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= index;
    cfg_chan.data <= CFG_DW'(value);
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int transp);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_TRANSP, transp);
  endtask

  // get or paint on a pixel never written turns into a put
  task automatic issue_request(input logic [1:0] op, input int x, input int y,
                               input logic [31:0] colour);
    logic [1:0] kind;
    bit         inb;
    int         idx;
    kind = op;
    idx = 0;
    inb = (x >= 0 && y >= 0 && x < frame_w && y < frame_h);
    if (inb) idx = y * frame_w + x;
    if (inb && (kind == REQ_GET || kind == REQ_PAINT) && !pixel_valid[idx]) kind = REQ_PUT;
    if (inb && kind == REQ_PUT) pixel_valid[idx] = 1'b1;
    if (kind == REQ_CLEAR) begin
      for (int p = 0; p < frame_w * frame_h; p++) pixel_valid[p] = 1'b1;
      clear_tail = frame_w * frame_h;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= kind;
    in_chan.pos_x <= 16'(x);
    in_chan.pos_y <= 16'(y);
    in_chan.colour <= colour;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (clear_tail + 8) @(negedge clk);
    clear_tail = 0;
  endtask

  task automatic random_requests(input int count);
    logic [1:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [31:0]        c;
    int                 roll;
    for (int i = 0; i < count; i++) begin
      px = 16'($urandom);
      py = 16'($urandom);
      c = $urandom;
      roll = $urandom_range(99);
      if (roll < 10) begin
        op = 2'($urandom_range(3));
      end else begin
        roll = $urandom_range(99);
        op = (roll < 33) ? REQ_PUT : (roll < 66) ? REQ_PAINT : (roll < 97) ? REQ_GET : REQ_CLEAR;
        if (frame_w > 0 && $urandom_range(9) != 0) px = 16'($urandom_range(frame_w - 1));
        else if ($urandom_range(1) != 0) px = 16'(frame_w);
        else px = -16'sd1;
        if (frame_h > 0 && $urandom_range(9) != 0) py = 16'($urandom_range(frame_h - 1));
        else if ($urandom_range(1) != 0) py = 16'(frame_h);
        else py = -16'sd1;
        case ($urandom_range(7))
          0: begin
            c[31:24] = 8'h00;
          end
          1: begin
            c[31:24] = 8'hFF;
          end
          default: begin
          end
        endcase
      end
      if (op == REQ_CLEAR && frame_w * frame_h > 4096) op = REQ_GET;
      issue_request(op, px, py, c);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_PUT;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.colour = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_WIDTH;
    cfg_chan.data = '0;
    stall_cycles = 0;
    frame_w = 0;
    frame_h = 0;
    clear_tail = 0;
    send_idle_pct = 34;
    recv_idle_pct = 67;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty frame: everything out of bounds
    configure(0, 0, 0);
    issue_request(REQ_PUT, 0, 0, 32'hFFFF_FFFF);
    issue_request(REQ_PAINT, 0, 0, 32'h8012_3456);
    issue_request(REQ_GET, 0, 0, 32'h0);
    issue_request(REQ_CLEAR, 0, 0, 32'h0);
    wait_idle();

    configure(4, 3, 1);
    issue_request(REQ_CLEAR, 5, 5, 32'hDEAD_BEEF);
    issue_request(REQ_GET, 3, 2, 32'h0);
    issue_request(REQ_PUT, 3, 2, 32'hFFFF_FFFF);
    issue_request(REQ_GET, 3, 2, 32'h0);
    issue_request(REQ_PUT, 0, 0, 32'h80FF_8000);
    issue_request(REQ_PAINT, 0, 0, 32'h0012_3456);
    issue_request(REQ_PAINT, 0, 0, 32'h8000_00FF);
    issue_request(REQ_GET, 0, 0, 32'h0);
    issue_request(REQ_PAINT, 0, 0, 32'hFF00_FF00);
    issue_request(REQ_GET, 0, 0, 32'h0);
    issue_request(REQ_PUT, 4, 0, 32'h1234_5678);
    issue_request(REQ_GET, 0, 3, 32'h0);
    issue_request(REQ_GET, -1, 0, 32'h0);
    issue_request(REQ_PAINT, 0, -1, 32'hFFFF_FFFF);
    issue_request(REQ_GET, -32768, -32768, 32'h0);
    issue_request(REQ_GET, 32767, 32767, 32'h0);
    issue_request(REQ_PUT, 1, 1, 32'h0000_0000);
    issue_request(REQ_PAINT, 1, 1, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(CFG_TRANSP, 0);
    issue_request(REQ_CLEAR, 0, 0, 32'h0);
    issue_request(REQ_GET, 2, 1, 32'h0);
    issue_request(REQ_PAINT, 2, 1, 32'h7F7F_7F7F);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 34;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(phase_w[ph], phase_h[ph], phase_t[ph]);
      issue_request(REQ_CLEAR, 0, 0, 32'h0);
      random_requests(104);
      wait_idle();
    end

    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("blended_pixel_framebuffer test passed");
    end else begin
      $display("blended_pixel_framebuffer test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpf_pkg.sv
rtl/core/bpf_channels.sv
rtl/core/bpf_front.sv
rtl/core/bpf_queue.sv
rtl/core/bpf_back.sv
rtl/core/blended_pixel_framebuffer.sv
rtl/core/bpf_checker.sv
sim/blended_pixel_framebuffer_checker.sv
sim/blended_pixel_framebuffer_tb.sv
